### design/nft_pkg.sv
// nft_pkg: types and constants for the notification fade timer
// used by nft_cfg_regs, nft_ratio_unit and notification_fade_timer_unit
package nft_pkg;

    localparam int COUNT_WIDTH = 20;
    localparam int ADDR_WIDTH  = 4;
    localparam int DATA_WIDTH  = 32;
    localparam int PROD_WIDTH  = 40;
    localparam int DEN_WIDTH   = 32;
    localparam int QUO_WIDTH   = 8;
    localparam int STEP_WIDTH  = 3;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_DISMISS = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] REG_DISPLAY = 2'd0;
    localparam logic [1:0] REG_FADE_IN = 2'd1;
    localparam logic [1:0] REG_BASE    = 2'd2;

    localparam logic [15:0] DISPLAY_RESET = 16'd0;
    localparam logic [15:0] FADE_IN_RESET = 16'd200;
    localparam logic [7:0]  BASE_RESET    = 8'd217;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] fade_ms;
    } nft_in_t;

    typedef struct packed {
        logic [7:0] opacity;
        logic       dismiss_due;
        logic       fade_done;
        logic       animating;
        logic       leaving;
    } nft_out_t;

    typedef struct packed {
        logic [15:0] display_ms;
        logic [15:0] ramp_ticks;
        logic [7:0]  base_opacity;
    } nft_cfg_t;

    typedef struct packed {
        logic [7:0]  base;
        logic [15:0] e_num;
        logic [15:0] e_den;
        logic [15:0] x_num;
        logic [15:0] x_den;
    } nft_ratio_op_t;

    typedef struct packed {
        logic busy;
        logic done;
    } nft_ratio_stat_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL_E,
        U_MUL_X,
        U_MUL_D,
        U_DIV,
        U_DONE
    } nft_unit_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_CALC,
        C_HOLD
    } nft_ctrl_state_t;

endpackage

### design/nft_cfg_regs.sv
// nft_cfg_regs: apb register file for display time, fade-in length and base opacity
// depends on nft_pkg
module nft_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nft_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [nft_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [nft_pkg::DATA_WIDTH-1:0] prdata,
    output logic                          pready,
    output nft_pkg::nft_cfg_t             cfg
);
    import nft_pkg::*;

    logic [15:0] display_reg;
    logic [15:0] fade_in_reg;
    logic [7:0]  base_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_reg <= DISPLAY_RESET;
            fade_in_reg <= FADE_IN_RESET;
            base_reg    <= BASE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DISPLAY: display_reg <= pwdata[15:0];
                REG_FADE_IN: fade_in_reg <= pwdata[15:0];
                REG_BASE:    base_reg    <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DISPLAY: prdata = {16'd0, display_reg};
            REG_FADE_IN: prdata = {16'd0, fade_in_reg};
            REG_BASE:    prdata = {24'd0, base_reg};
            default:     prdata = '0;
        endcase
    end

    assign cfg.display_ms   = display_reg;
    assign cfg.ramp_ticks   = fade_in_reg;
    assign cfg.base_opacity = base_reg;

endmodule

### design/nft_ratio_unit.sv
// nft_ratio_unit: base * e_num * x_num / (e_den * x_den) on one shared multiplier
// followed by a restoring divider, one quotient bit per cycle; depends on nft_pkg
module nft_ratio_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  nft_pkg::nft_ratio_op_t      op,
    output nft_pkg::nft_ratio_stat_t    stat,
    output logic [nft_pkg::QUO_WIDTH-1:0] quotient
);
    import nft_pkg::*;

    nft_unit_state_t            st_reg, st_next;
    nft_ratio_op_t              op_reg;
    logic [PROD_WIDTH-1:0]      acc_reg;
    logic [PROD_WIDTH-2:0]      dsh_reg;
    logic [QUO_WIDTH-1:0]       quo_reg;
    logic [STEP_WIDTH-1:0]      cnt_reg;

    logic [23:0]                mul_a;
    logic [15:0]                mul_b;
    logic [PROD_WIDTH-1:0]      mul_p;
    logic [PROD_WIDTH:0]        diff;
    logic                       qbit;

    // shared multiplier operand select
    always_comb
    begin
        case (st_reg)
            U_MUL_E:
            begin
                mul_a = {16'd0, op_reg.base};
                mul_b = op_reg.e_num;
            end
            U_MUL_X:
            begin
                mul_a = acc_reg[23:0];
                mul_b = op_reg.x_num;
            end
            U_MUL_D:
            begin
                mul_a = {8'd0, op_reg.e_den};
                mul_b = op_reg.x_den;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
    assign diff  = {1'b0, acc_reg} - {2'b00, dsh_reg};
    assign qbit  = !diff[PROD_WIDTH];

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            U_IDLE:  if (start) st_next = U_MUL_E;
            U_MUL_E: st_next = U_MUL_X;
            U_MUL_X: st_next = U_MUL_D;
            U_MUL_D: st_next = U_DIV;
            U_DIV:   if (cnt_reg == '0) st_next = U_DONE;
            U_DONE:  st_next = U_IDLE;
            default: st_next = U_IDLE;
        endcase
    end

    always_comb
    begin
        stat.busy = (st_reg != U_IDLE);
        stat.done = (st_reg == U_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= U_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    op_reg <= op;
                end
            end
            U_MUL_E: acc_reg <= mul_p;
            U_MUL_X: acc_reg <= mul_p;
            U_MUL_D:
            begin
                dsh_reg <= {mul_p[DEN_WIDTH-1:0], 7'd0};
                cnt_reg <= STEP_WIDTH'(QUO_WIDTH - 1);
            end
            U_DIV:
            begin
                if (qbit)
                begin
                    acc_reg <= diff[PROD_WIDTH-1:0];
                end
                quo_reg <= {quo_reg[QUO_WIDTH-2:0], qbit};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            default: ;
        endcase
    end

    assign quotient = quo_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> !stat.done)
        else $error("done held longer than one cycle");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> st_reg == U_IDLE)
        else $error("start while unit busy");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == U_DIV |-> dsh_reg != '0)
        else $error("zero divisor in divide step");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == U_MUL_D |=> st_reg == U_DIV ##8 st_reg == U_DONE)
        else $error("divide step count wrong");

endmodule

### design/notification_fade_timer_unit.sv
// notification_fade_timer_unit: top level of the overlay fade timer
// depends on nft_pkg, nft_cfg_regs, nft_ratio_unit
//
// channel   direction  handshake                   payload
// in        to block   in_valid / in_ready         in_data  (nft_in_t)
// out       from block out_valid / out_ready       out_data (nft_out_t)
// cfg       to block   psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// from acceptance to a loaded result a beat passes through the start register, three products
// on the shared multiplier, eight restoring divide steps and the done state
// the counters update at acceptance; in_ready is high only while idle
// a result waits in the output register; the next beat may be taken meanwhile
// and its result holds in the divider until the output register frees up
// reset is asynchronous, active low, no clearing pass
module notification_fade_timer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  nft_pkg::nft_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output nft_pkg::nft_out_t              out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nft_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [nft_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [nft_pkg::DATA_WIDTH-1:0] prdata,
    output logic                           pready
);
    import nft_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    nft_cfg_t                 cfg;
    nft_ratio_op_t            rop;
    nft_ratio_stat_t          rstat;
    logic [QUO_WIDTH-1:0]     quo;

    nft_ctrl_state_t          st_reg, st_next;
    logic                     start_reg;
    logic                     out_valid_reg, out_valid_next;
    nft_out_t                 out_reg;

    logic [COUNT_WIDTH-1:0]   shown_reg, shown_next;
    logic                     exit_reg, exit_next;
    logic [COUNT_WIDTH-1:0]   exit_el_reg, exit_el_next;
    logic [15:0]              exit_len_reg, exit_len_next;

    logic                     accept;
    logic                     slot_free;
    logic                     load_out;
    logic [COUNT_WIDTH-1:0]   fade_in_ext;
    logic [COUNT_WIDTH-1:0]   display_ext;
    logic [COUNT_WIDTH-1:0]   x_den_ext;
    logic [15:0]              x_den;
    logic                     fin;
    logic                     due;
    logic                     anim;

    nft_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nft_ratio_unit u_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .op       (rop),
        .stat     (rstat),
        .quotient (quo)
    );

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // state update for the accepted beat
    always_comb
    begin
        shown_next    = shown_reg;
        exit_next     = exit_reg;
        exit_el_next  = exit_el_reg;
        exit_len_next = exit_len_reg;
        if (accept)
        begin
            case (in_data.opcode)
                OP_TICK:
                begin
                    if (shown_reg != COUNT_MAX)
                    begin
                        shown_next = shown_reg + 1'b1;
                    end
                    if (exit_reg && exit_el_reg != COUNT_MAX)
                    begin
                        exit_el_next = exit_el_reg + 1'b1;
                    end
                end
                OP_DISMISS:
                begin
                    if (exit_reg)
                    begin
                        if (in_data.fade_ms != 16'd0 && in_data.fade_ms < exit_len_reg)
                        begin
                            exit_len_next = in_data.fade_ms;
                        end
                    end
                    else
                    begin
                        exit_next     = 1'b1;
                        exit_el_next  = '0;
                        exit_len_next = (in_data.fade_ms == 16'd0) ? 16'd1 : in_data.fade_ms;
                    end
                end
                OP_RESTART: shown_next = '0;
                default:    ;
            endcase
        end
    end

    // ratio operands and flags from the updated state
    assign fade_in_ext = COUNT_WIDTH'(cfg.ramp_ticks);
    assign display_ext = COUNT_WIDTH'(cfg.display_ms);
    assign x_den       = (exit_len_reg == 16'd0) ? 16'd1 : exit_len_reg;
    assign x_den_ext   = COUNT_WIDTH'(x_den);

    always_comb
    begin
        rop.base = cfg.base_opacity;
        if (cfg.ramp_ticks == 16'd0)
        begin
            rop.e_num = 16'd1;
            rop.e_den = 16'd1;
        end
        else
        begin
            rop.e_den = cfg.ramp_ticks;
            rop.e_num = (shown_reg < fade_in_ext) ? shown_reg[15:0] : cfg.ramp_ticks;
        end
        if (exit_reg)
        begin
            rop.x_den = x_den;
            rop.x_num = (exit_el_reg < x_den_ext) ? (x_den - exit_el_reg[15:0]) : 16'd0;
        end
        else
        begin
            rop.x_den = 16'd1;
            rop.x_num = 16'd1;
        end
    end

    assign fin  = exit_reg && (exit_el_reg >= COUNT_WIDTH'(exit_len_reg));
    assign due  = (cfg.display_ms != 16'd0) && !exit_reg && (shown_reg >= display_ext);
    assign anim = (shown_reg < fade_in_ext) || (exit_reg && !fin);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            C_IDLE: if (accept) st_next = C_CALC;
            C_CALC:
            begin
                if (rstat.done)
                begin
                    st_next = slot_free ? C_IDLE : C_HOLD;
                end
            end
            C_HOLD: if (slot_free) st_next = C_IDLE;
            default: st_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (st_reg == C_IDLE);
        load_out = slot_free && ((st_reg == C_CALC && rstat.done) || st_reg == C_HOLD);
        out_valid_next = load_out || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= C_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            shown_reg     <= '0;
            exit_reg      <= 1'b0;
            exit_el_reg   <= '0;
            exit_len_reg  <= 16'd1;
        end
        else
        begin
            st_reg        <= st_next;
            start_reg     <= accept;
            out_valid_reg <= out_valid_next;
            shown_reg     <= shown_next;
            exit_reg      <= exit_next;
            exit_el_reg   <= exit_el_next;
            exit_len_reg  <= exit_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.opacity     <= quo;
            out_reg.dismiss_due <= due;
            out_reg.fade_done   <= fin;
            out_reg.animating   <= anim;
            out_reg.leaving     <= exit_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        exit_reg |-> exit_len_reg != 16'd0)
        else $error("exit length zero while exiting");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready && start_reg)
        else $error("ratio unit not started after accepted beat");

    a_opacity_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_reg.opacity <= cfg.base_opacity)
        else $error("opacity above base");

    a_state_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(shown_reg) && $stable(exit_reg) && $stable(exit_len_reg))
        else $error("timer state changed without a beat");

endmodule
